// File: sv/ad32_pkg.sv
// ----------------------------------------------------------------------------
// ad32_pkg
// Shared codes and constants of the 32-bit arithmetic decoder.
// ----------------------------------------------------------------------------
`default_nettype none
package ad32_pkg;
    localparam logic [2:0] FUNC_PUSH   = 3'd0;
    localparam logic [2:0] FUNC_END    = 3'd1;
    localparam logic [2:0] FUNC_START  = 3'd2;
    localparam logic [2:0] FUNC_TARGET = 3'd3;
    localparam logic [2:0] FUNC_DECODE = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_TGT   = 2'd1;
    localparam logic [1:0] ST_UNDERRUN = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic [31:0] HALF_MARK  = 32'h8000_0000;
    localparam logic [31:0] MIN_RANGE  = 32'h0001_0000;
    localparam logic [31:0] BELOW_HALF = 32'h7fff_ffff;
    localparam logic [31:0] LOW_INIT   = 32'h0000_0001;
    localparam logic [31:0] HIGH_INIT  = 32'hffff_ffff;
endpackage
`default_nettype wire

// File: sv/ad32_if.sv
// ----------------------------------------------------------------------------
// ad32 channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none
interface ad32_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [7:0]  data_byte;
    logic [16:0] total;
    logic [15:0] cum_lo;
    logic [16:0] cum_hi;
    modport source (output valid, func, data_byte, total, cum_lo, cum_hi,
                    input ready);
    modport sink   (input valid, func, data_byte, total, cum_lo, cum_hi,
                    output ready);
endinterface

interface ad32_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] count_value;
    logic [1:0]  status;
    logic        target_taken;
    modport source (output valid, count_value, status, target_taken, input ready);
    modport sink   (input valid, count_value, status, target_taken, output ready);
endinterface
`default_nettype wire

// File: sv/arithmetic_decoder_32bit_core.sv
// ----------------------------------------------------------------------------
// arithmetic_decoder_32bit_core
// 32-bit interval decoder with a byte queue, a shared bit-serial divider and
// a renormalization step that shifts one bit per cycle unless it waits for queue read data.
// ----------------------------------------------------------------------------
// Push, mark end and unused codes go straight from idle to the response state.
// Start loads four code bytes; each queue pop after the first waits for fresh read data.
// Get target divides the range by the total, then the code offset by a nonzero step.
// Decode runs the high and low multiply states, then renormalization shifts and rounding steps.
// One request at a time; a new request is taken once the response is taken.
// Synchronous active-low reset clears control and interval state; queue data is not cleared.
`default_nettype none
module arithmetic_decoder_32bit_core
    import ad32_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    ad32_req_if.sink    i_req,
    ad32_rsp_if.source  o_rsp
);
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [PW-1:0] LAST_P  = PW'(QUEUE_DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_DIVA, S_DIVB, S_MULH, S_MULL, S_RENORM, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic [31:0] r_low, n_low, r_high, n_high, r_code, n_code, r_step, n_step;
    logic [7:0]  r_buf, n_buf;
    logic [3:0]  r_bits, n_bits;
    logic [CW-1:0] r_count, n_count;
    logic [PW-1:0] r_head, n_head;
    logic        r_end, n_end;
    logic [16:0] r_total, n_total, r_hc, n_hc;
    logic [15:0] r_lc, n_lc, r_cv, n_cv;
    logic [1:0]  r_status, n_status;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_quo, n_quo, r_div, n_div;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_fresh;
    logic [7:0]  r_rd;
    logic [7:0]  mem [QUEUE_DEPTH];

    logic          accept, do_write, do_pop;
    logic [CW:0]   tail_sum;
    logic [PW-1:0] tail;
    logic [31:0]   mul_b, product, diff;
    logic [32:0]   shifted;
    logic [3:0]    bl;
    logic [7:0]    nb;

    assign accept      = i_req.valid & i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = (r_state == S_OUT);
    assign o_rsp.count_value  = r_cv;
    assign o_rsp.status       = r_status;
    assign o_rsp.target_taken = (r_step != 32'd0);

    assign tail_sum = {1'b0, (CW)'(r_head)} + {1'b0, r_count};
    assign tail     = (tail_sum >= (CW+1)'(QUEUE_DEPTH))
                    ? PW'(tail_sum - (CW+1)'(QUEUE_DEPTH)) : PW'(tail_sum);
    assign do_write = accept && i_req.func == FUNC_PUSH && r_count < DEPTH_C;

    // shared multiplier: high count first, then low count
    assign mul_b   = (r_state == S_MULH) ? {15'd0, r_hc} : {16'd0, r_lc};
    assign product = r_step * mul_b;
    assign shifted = {r_rem[31:0], r_quo[31]};
    assign diff    = r_high - r_low;

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            mem[tail] <= i_req.data_byte;
        end
        r_rd <= mem[r_head];
    end

    always_comb begin
        n_state = r_state; n_low = r_low; n_high = r_high; n_code = r_code;
        n_step = r_step; n_buf = r_buf; n_bits = r_bits; n_count = r_count;
        n_head = r_head; n_end = r_end; n_total = r_total; n_hc = r_hc;
        n_lc = r_lc; n_cv = r_cv; n_status = r_status; n_rem = r_rem;
        n_quo = r_quo; n_div = r_div; n_cnt = r_cnt; do_pop = 1'b0;
        bl = 4'd0; nb = 8'd0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status = ST_OK; n_cv = 16'd0; n_state = S_OUT;
                    n_total = (i_req.total == 17'd0) ? 17'd1 : i_req.total;
                    n_hc = i_req.cum_hi; n_lc = i_req.cum_lo;
                    unique case (i_req.func)
                        FUNC_PUSH: begin
                            if (r_count < DEPTH_C) n_count = r_count + 1'b1;
                            else n_status = ST_FULL;
                        end
                        FUNC_END: n_end = 1'b1;
                        FUNC_START: begin
                            n_low = LOW_INIT; n_high = HIGH_INIT; n_step = 32'd0;
                            n_buf = 8'd0; n_bits = 4'd0; n_code = 32'd0;
                            n_cnt = 6'd0; n_state = S_START;
                        end
                        FUNC_TARGET: begin
                            n_rem = 33'd0; n_quo = r_high - r_low + 32'd1;
                            n_div = {15'd0, n_total}; n_cnt = 6'd0; n_state = S_DIVA;
                        end
                        FUNC_DECODE: begin
                            if (r_step == 32'd0) n_status = ST_NO_TGT;
                            else n_state = S_MULH;
                        end
                        default: ;
                    endcase
                end
            end
            S_START: begin
                if (r_count == '0) begin
                    if (!r_end) n_status = ST_UNDERRUN;
                    n_code = {r_code[23:0], 8'd0};
                    n_cnt = r_cnt + 6'd1;
                end else if (r_fresh) begin
                    do_pop = 1'b1;
                    n_code = {r_code[23:0], r_rd};
                    n_cnt = r_cnt + 6'd1;
                end
                if (n_cnt == 6'd4) n_state = S_OUT;
            end
            S_DIVA, S_DIVB: begin
                // restoring division, one quotient bit per cycle
                if (shifted >= {1'b0, r_div}) begin
                    n_rem = shifted - {1'b0, r_div}; n_quo = {r_quo[30:0], 1'b1};
                end else begin
                    n_rem = shifted; n_quo = {r_quo[30:0], 1'b0};
                end
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    if (r_state == S_DIVA) begin
                        n_step = n_quo;
                        if (n_quo == 32'd0) begin
                            n_cv = 16'(r_total - 17'd1); n_state = S_OUT;
                        end else begin
                            // divide the code offset by the new step
                            n_div = n_quo;
                            n_rem = 33'd0; n_quo = r_code - r_low;
                            n_cnt = 6'd0; n_state = S_DIVB;
                        end
                    end else begin
                        n_cv = (n_quo < {15'd0, r_total}) ? n_quo[15:0]
                                                         : 16'(r_total - 17'd1);
                        n_state = S_OUT;
                    end
                end
            end
            S_MULH: begin
                n_high = r_low + product - 32'd1; n_state = S_MULL;
            end
            S_MULL: begin
                n_low = r_low + product; n_step = 32'd0; n_state = S_RENORM;
            end
            S_RENORM: begin
                if (r_low >= HALF_MARK || r_high < HALF_MARK) begin
                    if (r_bits == 4'd0 && r_count != '0 && !r_fresh) begin
                        // hold until the queue read data is current
                    end else begin
                        nb = r_buf;
                        bl = r_bits;
                        if (r_bits == 4'd0) begin
                            bl = 4'd8;
                            if (r_count == '0) begin
                                nb = 8'd0;
                                if (!r_end) n_status = ST_UNDERRUN;
                            end else begin
                                nb = r_rd; do_pop = 1'b1;
                            end
                        end
                        bl = bl - 4'd1;
                        n_buf = nb; n_bits = bl;
                        n_high = {r_high[30:0], 1'b1};
                        n_low = (r_low[30:0] == 31'd0) ? LOW_INIT : {r_low[30:0], 1'b0};
                        n_code = {r_code[30:0], nb[bl[2:0]]};
                    end
                end else if (diff < MIN_RANGE) begin
                    if (r_high == HALF_MARK) n_high = BELOW_HALF;
                    else n_low = HALF_MARK;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (o_rsp.ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        if (do_pop) begin
            n_count = r_count - 1'b1;
            n_head = (r_head == LAST_P) ? '0 : r_head + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_low <= LOW_INIT; r_high <= HIGH_INIT;
            r_code <= '0; r_step <= '0; r_buf <= '0; r_bits <= '0;
            r_count <= '0; r_head <= '0; r_end <= 1'b0; r_fresh <= 1'b0;
            r_status <= ST_OK; r_cv <= '0;
        end else begin
            r_state <= n_state; r_low <= n_low; r_high <= n_high;
            r_code <= n_code; r_step <= n_step; r_buf <= n_buf; r_bits <= n_bits;
            r_count <= n_count; r_head <= n_head; r_end <= n_end;
            r_fresh <= !(do_pop || do_write);
            r_status <= n_status; r_cv <= n_cv;
        end
        r_total <= n_total; r_hc <= n_hc; r_lc <= n_lc;
        r_rem <= n_rem; r_quo <= n_quo; r_div <= n_div; r_cnt <= n_cnt;
    end
endmodule
`default_nettype wire

// File: tb/arithmetic_decoder_32bit_core_tb.sv
// ----------------------------------------------------------------------------
// arithmetic_decoder_32bit_core_tb
// Drives byte pushes, end marks, starts, get-target and decode requests into
// the 32-bit arithmetic decoder and checks every response against an interval
// decoder kept inside the bench or a typed-in response. Both channels stall in random bursts until the quiet tail.
// ----------------------------------------------------------------------------
`default_nettype none
module arithmetic_decoder_32bit_core_tb
    import ad32_pkg::*;
;

    localparam int QDEPTH    = 8;
    localparam int MAX_CYCLE = 1500000;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  data_byte;
        logic [16:0] total;
        logic [15:0] cum_lo;
        logic [16:0] cum_hi;
    } t_dec_req;

    typedef struct packed {
        logic [15:0] count_value;
        logic [1:0]  status;
        logic        target_taken;
    } t_dec_rsp;

    // Directed row: request plus an optional typed-in response.
    typedef struct {
        t_dec_req req;
        bit       fixed;
        t_dec_rsp rsp;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ad32_req_if req_ch ();
    ad32_rsp_if rsp_ch ();

    arithmetic_decoder_32bit_core #(.QUEUE_DEPTH(QDEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    always #6 i_clk = ~i_clk;

    // Interval decoder state
    logic [31:0] iv_low, iv_high, code_val, step;
    logic [7:0]  bit_buf;
    logic [3:0]  bits_left;
    logic [7:0]  byte_q [QDEPTH];
    int          q_count, q_head;
    bit          end_seen;

    t_dec_rsp    pending_rsp [$];
    int          mismatches = 0;
    int          rsp_seen = 0;
    int          cycle = 0;
    int          stall_left = 0;
    bit          quiet = 1'b0;
    int          n_func [8];

    function automatic logic [7:0] pop_stream_byte(inout logic [1:0] st);
        logic [7:0] b;
        if (q_count == 0) begin
            if (!end_seen) st = ST_UNDERRUN;
            return 8'h00;
        end
        b = byte_q[q_head];
        q_head = (q_head + 1) % QDEPTH;
        q_count--;
        return b;
    endfunction

    function automatic void restart_interval();
        iv_low = LOW_INIT;
        iv_high = HIGH_INIT;
        step = '0;
        bit_buf = '0;
        bits_left = '0;
        code_val = '0;
    endfunction

    function automatic void ref_init();
        restart_interval();
        q_count = 0;
        q_head = 0;
        end_seen = 1'b0;
        foreach (n_func[i]) n_func[i] = 0;
    endfunction

    function automatic t_dec_rsp decode_request(t_dec_req r);
        t_dec_rsp o;
        logic [1:0]  st;
        logic [31:0] tot, quot, lc, hc;
        o = '0;
        st = ST_OK;
        case (r.func)
            FUNC_PUSH: begin
                if (q_count >= QDEPTH) begin
                    st = ST_FULL;
                end else begin
                    byte_q[(q_head + q_count) % QDEPTH] = r.data_byte;
                    q_count++;
                end
            end
            FUNC_END: end_seen = 1'b1;
            FUNC_START: begin
                restart_interval();
                for (int i = 0; i < 4; i++)
                    code_val = {code_val[23:0], pop_stream_byte(st)};
            end
            FUNC_TARGET: begin
                tot = {15'd0, r.total};
                if (tot == 0) tot = 1;
                step = (iv_high - iv_low + 32'd1) / tot;
                quot = (step == 0) ? HIGH_INIT : (code_val - iv_low) / step;
                o.count_value = (quot < tot) ? quot[15:0] : 16'(tot - 1);
            end
            FUNC_DECODE: begin
                if (step == 0) begin
                    st = ST_NO_TGT;
                end else begin
                    lc = {16'd0, r.cum_lo};
                    hc = {15'd0, r.cum_hi};
                    iv_high = iv_low + step * hc - 32'd1;
                    iv_low = iv_low + step * lc;
                    step = '0;
                    forever begin
                        if (iv_low >= HALF_MARK || iv_high < HALF_MARK) begin
                            if (bits_left == 0) begin
                                bit_buf = pop_stream_byte(st);
                                bits_left = 4'd8;
                            end
                            bits_left--;
                            iv_high = {iv_high[30:0], 1'b1};
                            iv_low = {iv_low[30:0], 1'b0};
                            if (iv_low == 0) iv_low = LOW_INIT;
                            code_val = {code_val[30:0], bit_buf[bits_left[2:0]]};
                        end else if (iv_high - iv_low < MIN_RANGE) begin
                            if (iv_high == HALF_MARK) iv_high = BELOW_HALF;
                            else iv_low = HALF_MARK;
                        end else begin
                            break;
                        end
                    end
                end
            end
            default: ;
        endcase
        o.status = st;
        o.target_taken = (step != 0);
        return o;
    endfunction

    function automatic t_dec_req mk(logic [2:0] f, logic [7:0] b = 0, logic [16:0] t = 1,
                                    logic [15:0] lc = 0, logic [16:0] hc = 1);
        t_dec_req r;
        r.func = f;
        r.data_byte = b;
        r.total = t;
        r.cum_lo = lc;
        r.cum_hi = hc;
        return r;
    endfunction

    function automatic t_dir_row row(t_dec_req r, bit fx = 0, t_dec_rsp e = '0);
        t_dir_row d;
        d.req = r;
        d.fixed = fx;
        d.rsp = e;
        return d;
    endfunction

    // Drive one request and hold it until the handshake; valid stays high
    // after it unless an idle burst follows.
    task automatic send_request(t_dec_req r);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.func <= r.func;
        req_ch.data_byte <= r.data_byte;
        req_ch.total <= r.total;
        req_ch.cum_lo <= r.cum_lo;
        req_ch.cum_hi <= r.cum_hi;
        do @(posedge i_clk); while (!req_ch.ready);
        n_func[r.func]++;
    endtask

    task automatic apply(t_dir_row d);
        t_dec_rsp e;
        e = decode_request(d.req);
        if (d.fixed && e != d.rsp)
            $display("note: table row differs from predictor for func %0d", d.req.func);
        pending_rsp.push_back(d.fixed ? d.rsp : e);
        send_request(d.req);
    endtask

    task automatic random_symbol();
        logic [16:0] t, lo, hi;
        t = ($urandom_range(0, 9) == 0) ? 17'(65536) : 17'($urandom_range(1, 4000));
        apply(row(mk(FUNC_TARGET, 0, t)));
        lo = 17'($urandom_range(0, t - 1));
        hi = 17'($urandom_range(lo + 1, t));
        apply(row(mk(FUNC_DECODE, 0, 0, lo[15:0], hi)));
    endtask

    // Response side: random stall bursts, compare against the oldest expectation.
    always @(posedge i_clk) begin
        t_dec_rsp got, want;
        cycle <= cycle + 1;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                got = '{rsp_ch.count_value, rsp_ch.status, rsp_ch.target_taken};
                rsp_seen++;
                if (pending_rsp.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("error: response with none expected: %p", got);
                end else begin
                    want = pending_rsp.pop_front();
                    if (got != want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"error: rsp %0d expected count %h st %0d tt %0d,",
                                      " got count %h st %0d tt %0d"},
                                     rsp_seen, want.count_value, want.status,
                                     want.target_taken, got.count_value, got.status,
                                     got.target_taken);
                    end
                end
            end
            if (quiet) begin
                rsp_ch.ready <= 1'b1;
            end else if (stall_left > 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 10) - 1;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
        if (cycle >= MAX_CYCLE) begin
            $display("timeout after %0d cycles", cycle);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    t_dir_row dir_rows [$];

    initial begin
        int n;
        req_ch.valid = 1'b0;
        req_ch.func = FUNC_PUSH;
        req_ch.data_byte = '0;
        req_ch.total = 17'd1;
        req_ch.cum_lo = '0;
        req_ch.cum_hi = 17'd1;
        ref_init();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: error paths after reset, extremes, queue full and underrun.
        dir_rows.push_back(row(mk(FUNC_DECODE, 0, 0, 0, 1), 1, '{16'd0, ST_NO_TGT, 1'b0}));
        dir_rows.push_back(row(mk(3'd5), 1, '{16'd0, ST_OK, 1'b0}));
        dir_rows.push_back(row(mk(3'd7), 1, '{16'd0, ST_OK, 1'b0}));
        dir_rows.push_back(row(mk(FUNC_START), 1, '{16'd0, ST_UNDERRUN, 1'b0}));
        dir_rows.push_back(row(mk(FUNC_TARGET, 0, 17'd0)));
        dir_rows.push_back(row(mk(FUNC_DECODE, 0, 0, 16'hffff, 17'h1ffff)));
        dir_rows.push_back(row(mk(FUNC_TARGET, 0, 17'h1ffff)));
        dir_rows.push_back(row(mk(FUNC_DECODE, 0, 0, 16'd5, 17'd2)));
        for (int i = 0; i < QDEPTH; i++)
            dir_rows.push_back(row(mk(FUNC_PUSH, (i % 2) ? 8'hff : 8'h00), 1,
                                   '{16'd0, ST_OK, 1'b0}));
        dir_rows.push_back(row(mk(FUNC_PUSH, 8'h5a), 1, '{16'd0, ST_FULL, 1'b0}));
        dir_rows.push_back(row(mk(FUNC_START)));
        dir_rows.push_back(row(mk(FUNC_TARGET, 0, 17'd65536)));
        dir_rows.push_back(row(mk(FUNC_DECODE, 0, 0, 16'd0, 17'd65536)));
        dir_rows.push_back(row(mk(FUNC_TARGET, 0, 17'd1)));
        dir_rows.push_back(row(mk(FUNC_DECODE, 0, 0, 16'd0, 17'd1)));
        dir_rows.push_back(row(mk(FUNC_END), 1, '{16'd0, ST_OK, 1'b0}));
        dir_rows.push_back(row(mk(FUNC_START), 1, '{16'd0, ST_OK, 1'b0}));
        foreach (dir_rows[i]) apply(dir_rows[i]);

        // Random: mostly pushed bytes and symbol runs, with some starts, end marks and noise.
        n = 0;
        while (n < 1100) begin
            if (n > 950) quiet = 1'b1;
            case ($urandom_range(0, 19))
                0: begin apply(row(mk(3'($urandom_range(0, 7)), 8'($urandom),
                                      17'($urandom), 16'($urandom), 17'($urandom)))); n++; end
                1: begin apply(row(mk(FUNC_START))); n++; end
                2: begin apply(row(mk(FUNC_END))); n++; end
                default: begin
                    if (q_count < QDEPTH - 2 || $urandom_range(0, 7) == 0) begin
                        apply(row(mk(FUNC_PUSH, 8'($urandom))));
                        n++;
                    end
                    random_symbol();
                    n += 2;
                end
            endcase
        end
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        $display("covered %0d responses: push %0d, end %0d, start %0d, target %0d, decode %0d",
                 rsp_seen, n_func[FUNC_PUSH], n_func[FUNC_END], n_func[FUNC_START],
                 n_func[FUNC_TARGET], n_func[FUNC_DECODE]);
        $display("queue full, underrun, no-target and wraparound counts were exercised");
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
